// ----- sv/bphr_pkg.sv -----
// ----------------------------------------------------------------------------
// bphr_pkg
// Types and constants shared by the press/hold/repeat detector files.
// ----------------------------------------------------------------------------
package bphr_pkg;

   localparam int TIME_W  = 32;
   localparam int DELAY_W = 16;
   localparam int IDX_W   = 8;
   localparam int FLAG_W  = 3;
   localparam int CODE_W  = 2;

   // register indexes on the csr channel
   localparam logic [IDX_W-1:0] REG_LONG_PRESS   = 8'd0;
   localparam logic [IDX_W-1:0] REG_HOLD         = 8'd1;
   localparam logic [IDX_W-1:0] REG_FIRST_REPEAT = 8'd2;
   localparam logic [IDX_W-1:0] REG_REPEAT       = 8'd3;

   localparam logic [DELAY_W-1:0] RST_LONG_PRESS   = 16'd10;
   localparam logic [DELAY_W-1:0] RST_HOLD         = 16'd10;
   localparam logic [DELAY_W-1:0] RST_FIRST_REPEAT = 16'd1;
   localparam logic [DELAY_W-1:0] RST_REPEAT       = 16'd5;

   // flags that survive a released step
   localparam logic [FLAG_W-1:0] KEEP_ON_RELEASE = 3'b110;

   localparam logic [FLAG_W-1:0] FLAG_LONG   = 3'b001;
   localparam logic [FLAG_W-1:0] FLAG_HOLD   = 3'b010;
   localparam logic [FLAG_W-1:0] FLAG_REPEAT = 3'b100;

   localparam logic [CODE_W-1:0] CODE_RELEASED = 2'd0;
   localparam logic [CODE_W-1:0] CODE_PRESSED  = 2'd1;
   localparam logic [CODE_W-1:0] CODE_LONG     = 2'd2;
   localparam logic [CODE_W-1:0] CODE_HOLD     = 2'd3;

   typedef enum logic [3:0] {
      ST_RELEASED = 4'b0001,
      ST_PRESSED  = 4'b0010,
      ST_LONG     = 4'b0100,
      ST_HOLD     = 4'b1000
   } state_type;

   typedef struct packed {
      logic [DELAY_W-1:0] long_press_delay;
      logic [DELAY_W-1:0] hold_delay;
      logic [DELAY_W-1:0] first_repeat_delay;
      logic [DELAY_W-1:0] repeat_delay;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] press_state;
      logic [FLAG_W-1:0] event_flags;
   } result_type;

   function automatic logic [CODE_W-1:0] state_code(input state_type st);
      logic [CODE_W-1:0] code;
      case (st)
         ST_RELEASED: code = CODE_RELEASED;
         ST_PRESSED:  code = CODE_PRESSED;
         ST_LONG:     code = CODE_LONG;
         ST_HOLD:     code = CODE_HOLD;
         default:     code = CODE_RELEASED;
      endcase
      return code;
   endfunction

endpackage

// ----- sv/bphr_if.sv -----
// ----------------------------------------------------------------------------
// bphr_if
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface bphr_req_if;
   logic                         valid;
   logic                         ready;
   logic [bphr_pkg::TIME_W-1:0]  now;
   logic                         button_down;
   modport source (output valid, now, button_down, input ready);
   modport sink   (input valid, now, button_down, output ready);
endinterface

interface bphr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bphr_pkg::CODE_W-1:0]  press_state;
   logic [bphr_pkg::FLAG_W-1:0]  event_flags;
   modport source (output valid, press_state, event_flags, input ready);
   modport sink   (input valid, press_state, event_flags, output ready);
endinterface

interface bphr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bphr_pkg::IDX_W-1:0]    index;
   logic [bphr_pkg::DELAY_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/button_press_hold_repeat_fsm.sv -----
// A sample's result is registered in the output register, or in the skid stage while the output is stalled.
// Throughput: one sample per cycle while the skid stage is empty; the state step is one combinational pass.
// A stalled result parks in a skid stage, so one more sample is taken during a stall.
// Reset: synchronous, active high; state released, flags and deadline zero,
// delays back to 10, 10, 1 and 5.
// ----------------------------------------------------------------------------
// button_press_hold_repeat_fsm
// Button long-press / hold / auto-repeat detector with delay registers.
// ----------------------------------------------------------------------------
module button_press_hold_repeat_fsm (
   input  logic         clock,
   input  logic         reset,
   bphr_req_if.sink     req_bus,
   bphr_rsp_if.source   rsp_bus,
   bphr_csr_if.sink     csr_bus
);

   bphr_pkg::cfg_type     cfg;
   bphr_pkg::result_type  step_result;
   bphr_pkg::result_type  rsp_data;
   logic                  req_fire;

   assign req_fire = req_bus.valid && req_bus.ready;

   bphr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .wr_ready (csr_bus.ready),
      .cfg      (cfg)
   );

   bphr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (req_fire),
      .now         (req_bus.now),
      .button_down (req_bus.button_down),
      .cfg         (cfg),
      .result      (step_result)
   );

   bphr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .in_data   (step_result),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_bus.ready)
   );

   assign rsp_bus.press_state = rsp_data.press_state;
   assign rsp_bus.event_flags = rsp_data.event_flags;

   // skid full means the output register is full too
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("skid stage holds a beat while output is empty");

   // long-pressed is only reached by raising the long-press flag
   a_long_has_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.press_state == bphr_pkg::CODE_LONG)
         |-> rsp_bus.event_flags[0])
      else $error("long-pressed state without long-press flag");

   // hold is only reached by raising the sticky hold flag
   a_hold_has_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.press_state == bphr_pkg::CODE_HOLD)
         |-> rsp_bus.event_flags[1])
      else $error("hold state without hold flag");

   // the result output is valid in the cycle after every accepted sample
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_bus.valid)
      else $error("accepted sample produced no result");

endmodule

// ----- sv/bphr_csr.sv -----
// ----------------------------------------------------------------------------
// bphr_csr
// Delay registers, written one beat at a time; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bphr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_valid,
   input  logic [bphr_pkg::IDX_W-1:0]    wr_index,
   input  logic [bphr_pkg::DELAY_W-1:0]  wr_data,
   output logic                          wr_ready,
   output bphr_pkg::cfg_type             cfg
);

   bphr_pkg::cfg_type cfg_ff;
   bphr_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            bphr_pkg::REG_LONG_PRESS:   cfg_in.long_press_delay   = wr_data;
            bphr_pkg::REG_HOLD:         cfg_in.hold_delay         = wr_data;
            bphr_pkg::REG_FIRST_REPEAT: cfg_in.first_repeat_delay = wr_data;
            bphr_pkg::REG_REPEAT:       cfg_in.repeat_delay       = wr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_delay   <= bphr_pkg::RST_LONG_PRESS;
         cfg_ff.hold_delay         <= bphr_pkg::RST_HOLD;
         cfg_ff.first_repeat_delay <= bphr_pkg::RST_FIRST_REPEAT;
         cfg_ff.repeat_delay       <= bphr_pkg::RST_REPEAT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/bphr_core.sv -----
// ----------------------------------------------------------------------------
// bphr_core
// Press state machine with deadline and event flags, hold and repeat sticky; one step per beat.
// ----------------------------------------------------------------------------
module bphr_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [bphr_pkg::TIME_W-1:0]   now,
   input  logic                          button_down,
   input  bphr_pkg::cfg_type             cfg,
   output bphr_pkg::result_type          result
);

   bphr_pkg::state_type              cur_state_ff, cur_state_in;
   bphr_pkg::state_type              prev_state_ff, prev_state_in;
   logic [bphr_pkg::FLAG_W-1:0]      flags_ff, flags_in;
   logic [bphr_pkg::TIME_W-1:0]      deadline_ff, deadline_in;

   logic                             arm;
   logic [bphr_pkg::DELAY_W-1:0]     arm_delay;
   logic [bphr_pkg::TIME_W-1:0]      armed;
   logic [bphr_pkg::TIME_W-1:0]      due;
   logic                             expired;
   logic [bphr_pkg::TIME_W-1:0]      rearm;

   // deadline armed on the first step of each timed state
   always_comb begin
      arm       = 1'b0;
      arm_delay = cfg.long_press_delay;
      case (cur_state_ff)
         bphr_pkg::ST_PRESSED: begin
            arm       = (prev_state_ff == bphr_pkg::ST_RELEASED);
            arm_delay = cfg.long_press_delay;
         end
         bphr_pkg::ST_LONG: begin
            arm       = (prev_state_ff == bphr_pkg::ST_PRESSED);
            arm_delay = cfg.hold_delay;
         end
         bphr_pkg::ST_HOLD: begin
            arm       = (prev_state_ff == bphr_pkg::ST_LONG);
            arm_delay = cfg.first_repeat_delay;
         end
         default: begin
            arm       = 1'b0;
            arm_delay = cfg.long_press_delay;
         end
      endcase
   end

   assign armed   = now + bphr_pkg::TIME_W'(arm_delay);
   assign due     = arm ? armed : deadline_ff;
   assign expired = (now >= due);
   assign rearm   = now + bphr_pkg::TIME_W'(cfg.repeat_delay);

   always_comb begin
      cur_state_in  = cur_state_ff;
      prev_state_in = cur_state_ff;
      flags_in      = flags_ff;
      deadline_in   = due;
      case (cur_state_ff)
         bphr_pkg::ST_RELEASED: begin
            if (button_down) begin
               cur_state_in = bphr_pkg::ST_PRESSED;
            end
            prev_state_in = bphr_pkg::ST_RELEASED;
            flags_in      = flags_ff & bphr_pkg::KEEP_ON_RELEASE;
            deadline_in   = deadline_ff;
         end
         bphr_pkg::ST_PRESSED: begin
            if (!button_down) begin
               cur_state_in = bphr_pkg::ST_RELEASED;
            end else if (expired) begin
               cur_state_in = bphr_pkg::ST_LONG;
               flags_in     = flags_ff | bphr_pkg::FLAG_LONG;
            end
         end
         bphr_pkg::ST_LONG: begin
            if (!button_down) begin
               cur_state_in = bphr_pkg::ST_RELEASED;
            end else if (expired) begin
               cur_state_in = bphr_pkg::ST_HOLD;
               flags_in     = flags_ff | bphr_pkg::FLAG_HOLD;
            end
         end
         bphr_pkg::ST_HOLD: begin
            cur_state_in = button_down ? bphr_pkg::ST_HOLD : bphr_pkg::ST_RELEASED;
            // repeat is checked even on the releasing step
            if (expired) begin
               flags_in    = flags_ff | bphr_pkg::FLAG_REPEAT;
               deadline_in = rearm;
            end
         end
         default: begin
            cur_state_in  = bphr_pkg::ST_RELEASED;
            prev_state_in = bphr_pkg::ST_RELEASED;
            deadline_in   = deadline_ff;
         end
      endcase
   end

   assign result.press_state = bphr_pkg::state_code(cur_state_in);
   assign result.event_flags = flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff  <= bphr_pkg::ST_RELEASED;
         prev_state_ff <= bphr_pkg::ST_RELEASED;
         flags_ff      <= '0;
         deadline_ff   <= '0;
      end else if (step) begin
         cur_state_ff  <= cur_state_in;
         prev_state_ff <= prev_state_in;
         flags_ff      <= flags_in;
         deadline_ff   <= deadline_in;
      end
   end

endmodule

// ----- sv/bphr_skid.sv -----
// ----------------------------------------------------------------------------
// bphr_skid
// Result register with a skid stage so a new beat is taken during a stall.
// ----------------------------------------------------------------------------
module bphr_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bphr_pkg::result_type   in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output bphr_pkg::result_type   out_data,
   input  logic                   out_ready
);

   logic                  out_valid_ff;
   logic                  skid_valid_ff;
   bphr_pkg::result_type  out_data_ff;
   bphr_pkg::result_type  skid_data_ff;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= in_valid;
         end
      end else if (in_valid) begin
         // output stalled: park the beat
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready || !out_valid_ff) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the press / long-press / hold / repeat detector.
// Samples of time and button level go in on the req channel. A scoreboard
// tracks the state, flags and deadline on its own and checks every rsp beat.
// Delay registers are rewritten between phases, extremes included. Both the
// sample sender and the result receiver stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          STALL_LIMIT    = 500;
   localparam int          SETTLE_CYCLES  = 3;
   localparam int          PHASE_COUNT    = 14;
   localparam int          PHASE_SAMPLES  = 110;
   localparam int          IDLE_PERCENT   = 26;
   localparam logic [bphr_pkg::IDX_W-1:0]   BAD_INDEX_LOW  = 8'd4;
   localparam logic [bphr_pkg::IDX_W-1:0]   BAD_INDEX_HIGH = 8'hFF;
   localparam logic [bphr_pkg::DELAY_W-1:0] DELAY_MAX      = 16'hFFFF;

   logic clock = 1'b0;
   logic reset;

   bphr_req_if req_bus ();
   bphr_rsp_if rsp_bus ();
   bphr_csr_if csr_bus ();

   button_press_hold_repeat_fsm dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // detector state as the scoreboard sees it
   bphr_pkg::cfg_type                  delays;
   logic [bphr_pkg::CODE_W-1:0]        press_code;
   logic [bphr_pkg::CODE_W-1:0]        prior_code;
   logic [bphr_pkg::FLAG_W-1:0]        flag_word;
   logic [bphr_pkg::TIME_W-1:0]        due_time;

   bphr_pkg::result_type               press_results[$];
   int unsigned                        mismatch_count = 0;
   int unsigned                        quiet_cycles = 0;
   int unsigned                        samples_sent = 0;
   bit                                 calm = 1'b0;
   logic [bphr_pkg::TIME_W-1:0]        clock_time = '0;

   function automatic bphr_pkg::result_type next_press_result(
      input logic [bphr_pkg::TIME_W-1:0] t,
      input logic down);
      logic [bphr_pkg::FLAG_W-1:0] raised;
      bphr_pkg::result_type        res;
      raised = '0;
      case (press_code)
         bphr_pkg::CODE_RELEASED: begin
            if (down) press_code = bphr_pkg::CODE_PRESSED;
            prior_code = bphr_pkg::CODE_RELEASED;
            flag_word  = flag_word & bphr_pkg::KEEP_ON_RELEASE;
         end
         bphr_pkg::CODE_PRESSED: begin
            if (prior_code == bphr_pkg::CODE_RELEASED) begin
               due_time = t + bphr_pkg::TIME_W'(delays.long_press_delay);
            end
            if (!down) begin
               press_code = bphr_pkg::CODE_RELEASED;
            end else if (t >= due_time) begin
               press_code = bphr_pkg::CODE_LONG;
               raised     = bphr_pkg::FLAG_LONG;
            end
            prior_code = bphr_pkg::CODE_PRESSED;
         end
         bphr_pkg::CODE_LONG: begin
            if (prior_code == bphr_pkg::CODE_PRESSED) begin
               due_time = t + bphr_pkg::TIME_W'(delays.hold_delay);
            end
            if (!down) begin
               press_code = bphr_pkg::CODE_RELEASED;
            end else if (t >= due_time) begin
               press_code = bphr_pkg::CODE_HOLD;
               raised     = bphr_pkg::FLAG_HOLD;
            end
            prior_code = bphr_pkg::CODE_LONG;
         end
         default: begin
            if (prior_code == bphr_pkg::CODE_LONG) begin
               due_time = t + bphr_pkg::TIME_W'(delays.first_repeat_delay);
            end
            press_code = down ? bphr_pkg::CODE_HOLD : bphr_pkg::CODE_RELEASED;
            // the deadline is still tested on the release beat
            if (t >= due_time) begin
               raised   = bphr_pkg::FLAG_REPEAT;
               due_time = t + bphr_pkg::TIME_W'(delays.repeat_delay);
            end
            prior_code = bphr_pkg::CODE_HOLD;
         end
      endcase
      flag_word       = flag_word | raised;
      res.press_state = press_code;
      res.event_flags = flag_word;
      return res;
   endfunction

   // scoreboard: check result beats first, then queue the prediction
   always @(posedge clock) begin : score
      bphr_pkg::result_type want;
      if (reset) begin
         delays.long_press_delay   = bphr_pkg::RST_LONG_PRESS;
         delays.hold_delay         = bphr_pkg::RST_HOLD;
         delays.first_repeat_delay = bphr_pkg::RST_FIRST_REPEAT;
         delays.repeat_delay       = bphr_pkg::RST_REPEAT;
         press_code = bphr_pkg::CODE_RELEASED;
         prior_code = bphr_pkg::CODE_RELEASED;
         flag_word  = '0;
         due_time   = '0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (press_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result beat, expected none, actual state %0d flags %b",
                        $time, rsp_bus.press_state, rsp_bus.event_flags);
            end else begin
               want = press_results.pop_front();
               if (rsp_bus.press_state !== want.press_state) begin
                  mismatch_count++;
                  $display("%0t: press_state expected %0d actual %0d",
                           $time, want.press_state, rsp_bus.press_state);
               end
               if (rsp_bus.event_flags !== want.event_flags) begin
                  mismatch_count++;
                  $display("%0t: event_flags expected %b actual %b",
                           $time, want.event_flags, rsp_bus.event_flags);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            press_results.push_back(next_press_result(req_bus.now, req_bus.button_down));
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               bphr_pkg::REG_LONG_PRESS:   delays.long_press_delay   = csr_bus.data;
               bphr_pkg::REG_HOLD:         delays.hold_delay         = csr_bus.data;
               bphr_pkg::REG_FIRST_REPEAT: delays.first_repeat_delay = csr_bus.data;
               bphr_pkg::REG_REPEAT:       delays.repeat_delay       = csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   // receiver side: stall at random except in the calm phase
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // valid stays high across back-to-back beats; it drops only for a gap
   task automatic send_sample(input logic [bphr_pkg::TIME_W-1:0] t, input logic down);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.now         <= t;
      req_bus.button_down <= down;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (press_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bphr_pkg::IDX_W-1:0] idx,
                            input logic [bphr_pkg::DELAY_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic set_delays(input logic [bphr_pkg::DELAY_W-1:0] lp,
                             input logic [bphr_pkg::DELAY_W-1:0] hd,
                             input logic [bphr_pkg::DELAY_W-1:0] fr,
                             input logic [bphr_pkg::DELAY_W-1:0] rp);
      write_reg(bphr_pkg::REG_LONG_PRESS, lp);
      write_reg(bphr_pkg::REG_HOLD, hd);
      write_reg(bphr_pkg::REG_FIRST_REPEAT, fr);
      write_reg(bphr_pkg::REG_REPEAT, rp);
      csr_bus.valid <= 1'b0;
   endtask

   // walk all four states on the reset delays, repeat firing on release
   task automatic test_default_walk();
      send_sample(32'd100, 1'b1);
      send_sample(32'd100, 1'b1);
      send_sample(32'd110, 1'b1);
      send_sample(32'd110, 1'b1);
      send_sample(32'd120, 1'b1);
      send_sample(32'd121, 1'b1);
      send_sample(32'd122, 1'b1);
      send_sample(32'd127, 1'b0);
      send_sample(32'd128, 1'b0);
      send_sample(32'd200, 1'b1);
      send_sample(32'd200, 1'b0);
   endtask

   // zero delays fire on the arming beat itself
   task automatic test_zero_delays();
      drain_results();
      set_delays('0, '0, '0, '0);
      repeat (4) send_sample('0, 1'b1);
      send_sample('0, 1'b0);
      send_sample('0, 1'b0);
   endtask

   // deadline sum wraps modulo 2^32 at the top of the time range
   task automatic test_time_wrap();
      drain_results();
      set_delays(DELAY_MAX, DELAY_MAX, DELAY_MAX, DELAY_MAX);
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'hFFFF_FFF0, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
   endtask

   // writes to unmapped indexes must leave the delays alone
   task automatic test_ignored_index();
      drain_results();
      write_reg(BAD_INDEX_HIGH, DELAY_MAX);
      write_reg(BAD_INDEX_LOW, '0);
      csr_bus.valid <= 1'b0;
      send_sample(32'd1000, 1'b1);
      send_sample(32'd1001, 1'b1);
   endtask

   function automatic logic [bphr_pkg::DELAY_W-1:0] pick_delay();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return bphr_pkg::DELAY_W'($urandom_range(0, 12));
      if (r < 85) return ($urandom_range(0, 1) != 0) ? DELAY_MAX : '0;
      return bphr_pkg::DELAY_W'($urandom);
   endfunction

   task automatic advance_time();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80)      clock_time += $urandom_range(0, 3);
      else if (r < 95) clock_time += $urandom_range(0, 20);
      else             clock_time += $urandom_range(0, 131071);
   endtask

   // one press: button held for a while, then released for a few beats
   task automatic run_press_session();
      int unsigned held;
      int unsigned gap;
      held = $urandom_range(1, 40);
      gap  = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) clock_time = $urandom;
      repeat (held) begin
         advance_time();
         send_sample(clock_time, 1'b1);
      end
      repeat (gap) begin
         advance_time();
         send_sample(clock_time, 1'b0);
      end
   endtask

   task automatic run_noise_burst();
      repeat ($urandom_range(1, 8)) send_sample($urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_random_sessions();
      int unsigned phase_start;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         calm = (phase == PHASE_COUNT / 2);
         case (phase)
            0:       set_delays('0, '0, '0, '0);
            1:       set_delays(DELAY_MAX, DELAY_MAX, DELAY_MAX, DELAY_MAX);
            default: set_delays(pick_delay(), pick_delay(), pick_delay(), pick_delay());
         endcase
         phase_start = samples_sent;
         while (samples_sent - phase_start < PHASE_SAMPLES) begin
            if ($urandom_range(0, 9) == 0) run_noise_burst();
            else run_press_session();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.now         <= '0;
      req_bus.button_down <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= '0;
      csr_bus.data        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_walk();
      test_zero_delays();
      test_time_wrap();
      test_ignored_index();
      test_random_sessions();
      drain_results();

      if (mismatch_count == 0 && press_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
